FILE: design/ensemble_force_deviation_defines.svh
// Assertion macros shared by the deviation block
`ifndef ENSEMBLE_FORCE_DEVIATION_DEFINES_SVH
`define ENSEMBLE_FORCE_DEVIATION_DEFINES_SVH

// Immediate consequence check on the rising clock, idle under reset
`define EFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle consequence check on the rising clock, idle under reset
`define EFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/efd_pkg.sv
// Package: sizes, types and register indexes of the deviation block
`timescale 1ns / 1ps
package efd_pkg;
    localparam int MAX_MODELS  = 16;
    localparam int IDX_W       = $clog2(MAX_MODELS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_LANES   = 3;

    localparam logic [1:0] REG_MODEL_COUNT   = 2'd0;
    localparam logic [1:0] REG_VECTOR_MODE   = 2'd1;
    localparam logic [1:0] REG_RELATIVE_MODE = 2'd2;
    localparam logic [1:0] REG_EPSILON       = 2'd3;

    typedef enum logic [3:0] {
        ST_GATHER, ST_SUM, ST_MEANDIV, ST_SQ, ST_MSDIV, ST_SQRT,
        ST_NORM, ST_RELDIV, ST_OUT
    } t_state;

    // lane command from the sequencer
    typedef struct packed {
        logic clear;
        logic acc_sum;
        logic acc_sq;
        logic [IDX_W-1:0] idx;
    } t_lane_cmd;
endpackage

FILE: design/ensemble_force_deviation.sv
// Top level: gather force vectors, emit mean, deviation and relative deviation
//
// Channel | Direction | Handshake          | Payload
// in      | input     | i_valid / o_stall  | force_x, force_y, force_z
// out     | output    | o_valid / i_stall  | means, deviations, fault
// cfg     | input     | i_cfg_valid / o_cfg_ready | register index, data
//
// A non-final item is taken whenever the block is gathering. The final item of a gather
// of n models starts the sequence: the sums, the three mean divides, the squares, the
// mean-square divide in two halves and the root, then in relative mode the norm and its
// root and the ratio divide.
// Reset clears the gather count, the sequencer and the config registers; stores need no clearing.
// A held result stalls only the final item of the next gather and config writes.
`timescale 1ns / 1ps
`include "ensemble_force_deviation_defines.svh"
module ensemble_force_deviation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_mean_x,
    output logic signed [31:0] o_mean_y,
    output logic signed [31:0] o_mean_z,
    output logic [31:0]        o_deviation,
    output logic [31:0]        o_relative_deviation,
    output logic               o_divide_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int IW = efd_pkg::IDX_W;
    localparam int CW = efd_pkg::CNT_W;

    efd_pkg::t_state r_state, n_state;
    logic [4:0]  r_model_count;
    logic        r_vector_mode, r_relative_mode;
    logic [30:0] r_epsilon;
    logic [CW-1:0] r_count, r_n;
    logic [IW-1:0] r_idx;
    logic [1:0]  r_comp;
    logic        r_started;
    logic signed [31:0] r_mean [3];
    logic [63:0] r_acc_hi, r_acc_lo, r_q, r_q_hi;
    logic        r_phase;
    logic [31:0] r_dev;
    logic [63:0] r_norm_sq;
    logic        r_valid;

    logic        n_accept, n_last;
    logic [CW-1:0] n_target, n_next;
    efd_pkg::t_lane_cmd n_cmd;
    logic signed [36:0] n_sum [3];
    logic [63:0] n_sq [3];
    logic [31:0] n_mean_mag;
    logic [63:0] n_mean_sq;

    logic        n_div_start, n_sqrt_start;
    logic [63:0] n_div_num, n_div_den, n_sqrt_val;
    logic        w_div_busy, w_sqrt_busy;
    logic [63:0] w_quo, w_rem;
    logic [31:0] w_root;

    // configuration writes while idle
    assign o_cfg_ready = (r_state == efd_pkg::ST_GATHER) && !r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_count   <= 5'd1;
            r_vector_mode   <= 1'b1;
            r_relative_mode <= 1'b0;
            r_epsilon       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                efd_pkg::REG_MODEL_COUNT:   r_model_count   <= i_cfg_data[4:0];
                efd_pkg::REG_VECTOR_MODE:   r_vector_mode   <= i_cfg_data[0];
                efd_pkg::REG_RELATIVE_MODE: r_relative_mode <= i_cfg_data[0];
                efd_pkg::REG_EPSILON:       r_epsilon       <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // clamp model count and detect gather completion
    always_comb begin
        if (r_model_count == 5'd0) begin
            n_target = CW'(1);
        end else if (32'(r_model_count) > efd_pkg::MAX_MODELS) begin
            n_target = CW'(efd_pkg::MAX_MODELS);
        end else begin
            n_target = CW'(r_model_count);
        end
        n_next   = r_count + CW'(1);
        n_accept = i_valid && !o_stall;
        n_last   = (n_next >= n_target);
    end
    assign o_stall = (r_state != efd_pkg::ST_GATHER) || (r_valid && n_last);

    // lane command from the sequencer
    always_comb begin
        n_cmd.clear   = (r_state == efd_pkg::ST_GATHER);
        n_cmd.acc_sum = (r_state == efd_pkg::ST_SUM);
        n_cmd.acc_sq  = (r_state == efd_pkg::ST_SQ) && (r_comp == 2'd0);
        n_cmd.idx     = r_idx;
    end

    // square of one mean component for the norm
    always_comb begin
        n_mean_mag = r_mean[r_comp][31] ? 32'(-r_mean[r_comp]) : 32'(r_mean[r_comp]);
        n_mean_sq  = 64'(n_mean_mag) * 64'(n_mean_mag);
    end

    efd_lane u_lane_x (.i_clk, .i_wr(n_accept), .i_wr_idx(r_count[IW-1:0]),
        .i_wr_data(i_force_x), .i_cmd(n_cmd), .i_mean(r_mean[0]),
        .o_sum(n_sum[0]), .o_sq(n_sq[0]));
    efd_lane u_lane_y (.i_clk, .i_wr(n_accept), .i_wr_idx(r_count[IW-1:0]),
        .i_wr_data(i_force_y), .i_cmd(n_cmd), .i_mean(r_mean[1]),
        .o_sum(n_sum[1]), .o_sq(n_sq[1]));
    efd_lane u_lane_z (.i_clk, .i_wr(n_accept), .i_wr_idx(r_count[IW-1:0]),
        .i_wr_data(i_force_z), .i_cmd(n_cmd), .i_mean(r_mean[2]),
        .o_sum(n_sum[2]), .o_sq(n_sq[2]));

    efd_divider u_div (.i_clk, .i_rst_n, .i_start(n_div_start), .i_num(n_div_num),
        .i_den(n_div_den), .o_busy(w_div_busy), .o_quo(w_quo), .o_rem(w_rem));
    efd_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(n_sqrt_start), .i_val(n_sqrt_val),
        .o_busy(w_sqrt_busy), .o_root(w_root));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efd_pkg::ST_GATHER:  if (n_accept && n_last) n_state = efd_pkg::ST_SUM;
            efd_pkg::ST_SUM:     if (32'(r_idx) + 1 == 32'(r_n)) n_state = efd_pkg::ST_MEANDIV;
            efd_pkg::ST_MEANDIV:
                if (r_started && !w_div_busy && r_comp == 2'd2) n_state = efd_pkg::ST_SQ;
            efd_pkg::ST_SQ:
                if (r_comp == 2'd3 && 32'(r_idx) + 1 == 32'(r_n)) n_state = efd_pkg::ST_MSDIV;
            efd_pkg::ST_MSDIV:
                if ((r_acc_hi >= 64'(r_n)) || (r_started && !w_div_busy && r_phase))
                    n_state = efd_pkg::ST_SQRT;
            efd_pkg::ST_SQRT:
                if (r_started && !w_sqrt_busy)
                    n_state = r_relative_mode ? efd_pkg::ST_NORM : efd_pkg::ST_OUT;
            efd_pkg::ST_NORM:    if (r_started && !w_sqrt_busy) n_state = efd_pkg::ST_RELDIV;
            efd_pkg::ST_RELDIV:
                if (r_norm_sq == 64'd0 || (r_started && !w_div_busy)) n_state = efd_pkg::ST_OUT;
            efd_pkg::ST_OUT:     n_state = efd_pkg::ST_GATHER;
            default:             n_state = efd_pkg::ST_GATHER;
        endcase
    end

    // unit start strobes and operands
    always_comb begin
        n_div_start  = 1'b0;
        n_sqrt_start = 1'b0;
        n_div_num    = 64'(signed'(n_sum[r_comp]) < 0 ? -n_sum[r_comp] : n_sum[r_comp]);
        n_div_den    = 64'(r_n);
        n_sqrt_val   = r_q;
        unique case (r_state)
            efd_pkg::ST_MEANDIV: n_div_start = !r_started;
            efd_pkg::ST_MSDIV: begin
                n_div_start = !r_started && (r_acc_hi < 64'(r_n));
                n_div_num   = r_phase ? {w_rem[31:0], r_acc_lo[31:0]}
                                      : {r_acc_hi[31:0], r_acc_lo[63:32]};
            end
            efd_pkg::ST_SQRT:    n_sqrt_start = !r_started && (r_acc_hi < 64'(r_n));
            efd_pkg::ST_NORM: begin
                n_sqrt_start = !r_started && (r_comp == 2'd3);
                n_sqrt_val   = r_norm_sq;
            end
            efd_pkg::ST_RELDIV: begin
                n_div_start = !r_started && (r_norm_sq != 64'd0);
                n_div_num   = {16'd0, r_dev, 16'd0};
                n_div_den   = r_norm_sq;
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= efd_pkg::ST_GATHER;
            r_count   <= '0;
            r_idx     <= '0;
            r_comp    <= '0;
            r_started <= 1'b0;
            r_phase   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == efd_pkg::ST_OUT) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                efd_pkg::ST_GATHER: begin
                    r_idx <= '0; r_comp <= '0; r_started <= 1'b0; r_phase <= 1'b0;
                    r_acc_hi <= '0; r_acc_lo <= '0;
                    if (n_accept) begin
                        r_count <= n_last ? '0 : n_next;
                        r_n     <= n_next;
                    end
                end
                efd_pkg::ST_SUM:
                    r_idx <= (n_state == efd_pkg::ST_SUM) ? r_idx + IW'(1) : '0;
                efd_pkg::ST_MEANDIV: begin
                    if (r_started && !w_div_busy) begin
                        r_mean[r_comp] <= (!r_vector_mode && r_comp != 2'd0) ? 32'sd0 :
                            (n_sum[r_comp] < 0 ? -32'(w_quo) : 32'(w_quo));
                        r_comp    <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                        r_started <= 1'b0;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                efd_pkg::ST_SQ: begin
                    // one lane product per cycle into the 128-bit sum
                    if (r_comp != 2'd0 && (r_comp == 2'd1 || r_vector_mode)) begin
                        {r_acc_hi, r_acc_lo} <= {r_acc_hi, r_acc_lo}
                            + 128'(n_sq[r_comp - 2'd1]);
                    end
                    if (r_comp == 2'd3) begin
                        r_comp <= 2'd0;
                        r_idx  <= (n_state == efd_pkg::ST_MSDIV) ? '0 : r_idx + IW'(1);
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                efd_pkg::ST_MSDIV: begin
                    if (n_state == efd_pkg::ST_SQRT) begin
                        r_started <= 1'b0;
                        if (r_started && !w_div_busy) r_q <= {r_q_hi[31:0], w_quo[31:0]};
                    end else if (r_started && !w_div_busy) begin
                        r_started <= 1'b0;
                        r_phase   <= 1'b1;
                        r_q_hi    <= w_quo;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                efd_pkg::ST_SQRT: begin
                    r_started <= (n_state == efd_pkg::ST_SQRT);
                    r_norm_sq <= '0;
                    if (r_acc_hi >= 64'(r_n)) r_dev <= 32'hFFFF_FFFF;
                    else if (r_started && !w_sqrt_busy) r_dev <= w_root;
                end
                efd_pkg::ST_NORM: begin
                    // sum the squared mean components, take the root, then add epsilon
                    if (r_comp != 2'd3) begin
                        r_norm_sq <= r_norm_sq + n_mean_sq;
                        r_comp    <= r_comp + 2'd1;
                    end else if (r_started && !w_sqrt_busy) begin
                        r_norm_sq <= 64'(w_root) + 64'(r_epsilon);
                        r_started <= 1'b0;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                efd_pkg::ST_RELDIV: r_started <= 1'b1;
                efd_pkg::ST_OUT:    r_started <= 1'b0;
                default: ;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == efd_pkg::ST_OUT) begin
            o_mean_x    <= r_mean[0];
            o_mean_y    <= r_mean[1];
            o_mean_z    <= r_mean[2];
            o_deviation <= r_dev;
            o_divide_fault <= r_relative_mode && (r_norm_sq == 64'd0);
            if (!r_relative_mode) o_relative_deviation <= '0;
            else if (r_norm_sq == 64'd0 || w_quo[63:32] != 32'd0)
                o_relative_deviation <= 32'hFFFF_FFFF;
            else o_relative_deviation <= w_quo[31:0];
        end
    end
    assign o_valid = r_valid;

    `EFD_ASSERT_IMP(a_no_intake_busy, i_clk, i_rst_n,
        r_state != efd_pkg::ST_GATHER, o_stall, "intake open while busy")
    `EFD_ASSERT_NXT(a_out_after_done, i_clk, i_rst_n,
        r_state == efd_pkg::ST_OUT, r_valid, "result not presented")
    `EFD_ASSERT_IMP(a_count_range, i_clk, i_rst_n,
        1'b1, 32'(r_count) < efd_pkg::MAX_MODELS, "gather count out of range")
endmodule

FILE: design/efd_divider.sv
// Restoring divider, one quotient bit per cycle, 64 by 64 bits
`timescale 1ns / 1ps
module efd_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [63:0] r_quo, r_rem, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] n_trial;
    logic [63:0] n_shift;

    // shift in one numerator bit and try a subtract
    always_comb begin
        n_shift = {r_rem[62:0], r_quo[63]};
        n_trial = {1'b0, n_shift} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 7'd1;
            r_busy <= (r_cnt != 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!r_rem[63] && !n_trial[64]) begin
                r_rem <= n_trial[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

FILE: design/efd_sqrt.sv
// Bit-pair square root, one result bit per cycle, 64-bit radicand
`timescale 1ns / 1ps
module efd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_val;
    logic [65:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [65:0] n_rem, n_trial;

    // bring down two bits, trial subtract 4*root+1
    always_comb begin
        n_rem   = {r_rem[63:0], r_val[63:62]};
        n_trial = n_rem - {32'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_busy <= (r_cnt != 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[61:0], 2'b00};
            if (!n_trial[65]) begin
                r_rem  <= n_trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= n_rem;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

FILE: design/efd_lane.sv
// One component lane: stores one component per model, sums them, squares deviations
`timescale 1ns / 1ps
module efd_lane (
    input  logic                  i_clk,
    input  logic                  i_wr,
    input  logic [efd_pkg::IDX_W-1:0] i_wr_idx,
    input  logic signed [31:0]    i_wr_data,
    input  efd_pkg::t_lane_cmd    i_cmd,
    input  logic signed [31:0]    i_mean,
    output logic signed [36:0]    o_sum,
    output logic [63:0]           o_sq
);
    logic signed [31:0] r_store [efd_pkg::MAX_MODELS];
    logic signed [36:0] r_sum;
    logic [63:0]        r_sq;
    logic signed [31:0] n_val;
    logic signed [32:0] n_diff;
    logic [32:0]        n_mag;
    logic [63:0]        n_prod;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_store[i_wr_idx] <= i_wr_data;
        end
    end

    // deviation of one stored value from the mean, squared
    always_comb begin
        n_val  = r_store[i_cmd.idx];
        n_diff = 33'(n_val) - 33'(i_mean);
        n_mag  = n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
        n_prod = 64'(n_mag[31:0]) * 64'(n_mag[31:0]);
        if (n_mag[32]) begin
            n_prod = 64'hFFFF_FFFF_FFFF_FFFF;
        end
    end

    // accumulate the sum over the stored models and register the squared deviation
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            if (i_cmd.acc_sum) begin
                r_sum <= r_sum + 37'(n_val);
            end
            if (i_cmd.acc_sq) begin
                r_sq <= n_prod;
            end
        end
    end

    assign o_sum = r_sum;
    assign o_sq  = r_sq;
endmodule
